// ===== sv/psw_pkg.sv =====
// Package for the pointer speed window meter.
// Holds the payload structs, the divider request struct and the shared widths.
// No dependencies.
`timescale 1ns / 1ps

package psw_pkg;

    // Fixed field widths
    localparam int PSW_TIME_W    = 32;
    localparam int PSW_FIELD_W   = 16;
    localparam int PSW_WIN_W     = 16;
    localparam int PSW_SPEED_W   = 27;
    localparam int PSW_SUM_W     = 44;
    localparam int PSW_COUNT_W   = 17;
    localparam int PSW_POS_WIDTH = 16;

    // Shared divider: dividend as wide as the speed sum, divisor as wide as a time step
    localparam int PSW_DIV_NUM_W = PSW_SUM_W;
    localparam int PSW_DIV_DEN_W = PSW_TIME_W;
    localparam int PSW_DIV_CNT_W = $clog2(PSW_DIV_NUM_W + 1);

    localparam int unsigned PSW_MS_PER_S   = 1000;
    localparam logic [PSW_WIN_W-1:0] PSW_WIN_RESET = PSW_WIN_W'(1000);

    localparam logic [PSW_SPEED_W-1:0] PSW_SPEED_MAX = '1;
    localparam logic [PSW_COUNT_W-1:0] PSW_COUNT_MAX = '1;

    typedef struct packed {
        logic [PSW_TIME_W-1:0]         time_ms;
        logic signed [PSW_FIELD_W-1:0] pos_x;
        logic signed [PSW_FIELD_W-1:0] pos_y;
    } psw_in_t;

    typedef struct packed {
        logic                   accepted;
        logic [PSW_SPEED_W-1:0] current_speed;
        logic [PSW_SPEED_W-1:0] average_speed;
        logic                   window_closed;
    } psw_out_t;

    // Divider start request: operands and number of quotient bits to produce
    typedef struct packed {
        logic                     start;
        logic [PSW_DIV_CNT_W-1:0] bits;
        logic [PSW_DIV_NUM_W-1:0] num;
        logic [PSW_DIV_DEN_W-1:0] den;
    } psw_div_req_t;

endpackage

// ===== sv/pointer_speed_window_meter_top.sv =====
// Top level of the pointer speed window meter: sequencer, shared multiplier, state.
// Depends on psw_pkg, psw_isqrt and psw_divider.
`timescale 1ns / 1ps

// Pointer speed window meter.
// Input channel (in_valid/in_ready/in_data): one request per pointer sample, a
// millisecond timestamp and an x/y position. Every request gives exactly one
// result on the output channel (out_valid/out_ready/out_data): accepted flag,
// current speed in pixels per second, window average and window-closed flag.
// cfg_we/cfg_wdata write the window length in ms; write it only while idle.
// One request is worked on at a time; in_ready is high only when the
// sequencer is idle. A request with zero elapsed time goes from the
// difference step straight to the result. Other requests pass through the
// squares, the scalings by 1000, the bit-serial square root and the
// bit-serial speed division; a request that closes a window adds the
// average division (one bit per cycle over the 44-bit sum).
// The result sits in an output register: if the receiver stalls, the next
// request is still taken and worked on, and the sequencer waits only when a
// second result is ready before the first has gone.
// Reset clears the architectural state to zero and the window length to 1000 ms.

module pointer_speed_window_meter_top
    import psw_pkg::*;
#(
    parameter int POS_WIDTH = PSW_POS_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [PSW_WIN_W-1:0] cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  psw_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output psw_out_t             out_data
);

    // Datapath widths following from the position width
    localparam int EXT_W  = (POS_WIDTH > PSW_FIELD_W) ? POS_WIDTH : PSW_FIELD_W;
    localparam int SQ_W   = 2 * POS_WIDTH + 1;
    localparam int A_W    = SQ_W + 10;
    localparam int B_W    = (POS_WIDTH > 10) ? POS_WIDTH : 10;
    localparam int RAD_W  = SQ_W + 20;
    localparam int ROOT_W = (RAD_W + 1) / 2;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_DIFF = 11'b00000000010,
        ST_SQX  = 11'b00000000100,
        ST_SQY  = 11'b00000001000,
        ST_K1   = 11'b00000010000,
        ST_K2   = 11'b00000100000,
        ST_ROOT = 11'b00001000000,
        ST_DIVS = 11'b00010000000,
        ST_UPD  = 11'b00100000000,
        ST_DIVA = 11'b01000000000,
        ST_DONE = 11'b10000000000
    } psw_state_t;

    psw_state_t state_reg, state_next;

    // Architectural state
    logic [PSW_WIN_W-1:0]          window_ms_reg;
    logic signed [POS_WIDTH-1:0]   last_x_reg, last_x_next;
    logic signed [POS_WIDTH-1:0]   last_y_reg, last_y_next;
    logic [PSW_TIME_W-1:0]         last_time_reg, last_time_next;
    logic [PSW_TIME_W-1:0]         win_start_reg, win_start_next;
    logic [PSW_SPEED_W-1:0]        speed_now_reg, speed_now_next;
    logic [PSW_SPEED_W-1:0]        speed_avg_reg, speed_avg_next;
    logic [PSW_SUM_W-1:0]          speed_sum_reg, speed_sum_next;
    logic [PSW_COUNT_W-1:0]        count_reg, count_next;

    // Per-request working registers
    logic [PSW_TIME_W-1:0]         time_reg, time_next;
    logic signed [POS_WIDTH-1:0]   x_reg, x_next;
    logic signed [POS_WIDTH-1:0]   y_reg, y_next;
    logic [PSW_TIME_W-1:0]         dt_reg, dt_next;
    logic [POS_WIDTH-1:0]          ax_reg, ax_next;
    logic [POS_WIDTH-1:0]          ay_reg, ay_next;
    logic [RAD_W-1:0]              acc_reg, acc_next;
    logic [PSW_SPEED_W-1:0]        spd_reg, spd_next;
    logic                          acc_flag_reg, acc_flag_next;
    logic                          closed_reg, closed_next;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    psw_out_t                      out_data_reg, out_data_next;

    // Shared multiplier
    logic [A_W-1:0]                mul_a;
    logic [B_W-1:0]                mul_b;
    logic [A_W+B_W-1:0]            prod_full;
    logic [RAD_W-1:0]              prod;

    // Sub-units
    logic                          root_start;
    logic                          root_done;
    logic [ROOT_W-1:0]             root_val;
    psw_div_req_t                  div_req;
    logic                          div_done;
    logic [PSW_DIV_NUM_W-1:0]      div_quot;

    // Input decode and differences
    logic [EXT_W-1:0]              x_ext, y_ext;
    logic signed [POS_WIDTH:0]     dx, dy;
    logic [PSW_TIME_W-1:0]         elapsed;
    logic [PSW_SUM_W-1:0]          sum_upd;
    logic [PSW_COUNT_W-1:0]        count_upd;

    assign x_ext = EXT_W'(in_data.pos_x);
    assign y_ext = EXT_W'(in_data.pos_y);

    assign dx = {x_reg[POS_WIDTH-1], x_reg} - {last_x_reg[POS_WIDTH-1], last_x_reg};
    assign dy = {y_reg[POS_WIDTH-1], y_reg} - {last_y_reg[POS_WIDTH-1], last_y_reg};

    assign elapsed = time_reg - win_start_reg;

    // Multiplier operand selection: squares first, then two scalings by 1000
    always_comb
    begin
        case (state_reg)
            ST_SQX:
            begin
                mul_a = A_W'(ax_reg);
                mul_b = B_W'(ax_reg);
            end
            ST_SQY:
            begin
                mul_a = A_W'(ay_reg);
                mul_b = B_W'(ay_reg);
            end
            default:
            begin
                mul_a = acc_reg[A_W-1:0];
                mul_b = B_W'(PSW_MS_PER_S);
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign prod      = prod_full[RAD_W-1:0];

    // Running sum and count with the new speed, held once the count is full
    always_comb
    begin
        if (count_reg < PSW_COUNT_MAX)
        begin
            sum_upd   = speed_sum_reg + PSW_SUM_W'(spd_reg);
            count_upd = count_reg + 1'b1;
        end
        else
        begin
            sum_upd   = speed_sum_reg;
            count_upd = count_reg;
        end
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        last_time_next = last_time_reg;
        win_start_next = win_start_reg;
        speed_now_next = speed_now_reg;
        speed_avg_next = speed_avg_reg;
        speed_sum_next = speed_sum_reg;
        count_next     = count_reg;
        time_next      = time_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        dt_next        = dt_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        acc_next       = acc_reg;
        spd_next       = spd_reg;
        acc_flag_next  = acc_flag_reg;
        closed_next    = closed_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        root_start     = 1'b0;
        div_req        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    time_next  = in_data.time_ms;
                    x_next     = x_ext[POS_WIDTH-1:0];
                    y_next     = y_ext[POS_WIDTH-1:0];
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                dt_next     = time_reg - last_time_reg;
                ax_next     = dx[POS_WIDTH] ? POS_WIDTH'(-dx) : dx[POS_WIDTH-1:0];
                ay_next     = dy[POS_WIDTH] ? POS_WIDTH'(-dy) : dy[POS_WIDTH-1:0];
                closed_next = 1'b0;
                if (time_reg == last_time_reg)
                begin
                    acc_flag_next = 1'b0;
                    state_next    = ST_DONE;
                end
                else
                begin
                    acc_flag_next = 1'b1;
                    state_next    = ST_SQX;
                end
            end
            ST_SQX:
            begin
                acc_next   = prod;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                acc_next   = acc_reg + prod;
                state_next = ST_K1;
            end
            ST_K1:
            begin
                acc_next   = prod;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                acc_next   = prod;
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    div_req.start = 1'b1;
                    div_req.bits  = PSW_DIV_CNT_W'(ROOT_W);
                    div_req.num   = PSW_DIV_NUM_W'(root_val) << (PSW_DIV_NUM_W - ROOT_W);
                    div_req.den   = dt_reg;
                    state_next    = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                if (div_done)
                begin
                    if (|div_quot[PSW_DIV_NUM_W-1:PSW_SPEED_W])
                    begin
                        spd_next = PSW_SPEED_MAX;
                    end
                    else
                    begin
                        spd_next = div_quot[PSW_SPEED_W-1:0];
                    end
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                speed_now_next = spd_reg;
                last_x_next    = x_reg;
                last_y_next    = y_reg;
                last_time_next = time_reg;
                speed_sum_next = sum_upd;
                count_next     = count_upd;
                state_next     = ST_DONE;
                if (elapsed >= PSW_TIME_W'(window_ms_reg))
                begin
                    win_start_next = time_reg;
                    speed_sum_next = '0;
                    count_next     = '0;
                    closed_next    = 1'b1;
                    if (count_upd != '0)
                    begin
                        div_req.start = 1'b1;
                        div_req.bits  = PSW_DIV_CNT_W'(PSW_SUM_W);
                        div_req.num   = sum_upd;
                        div_req.den   = PSW_DIV_DEN_W'(count_upd);
                        state_next    = ST_DIVA;
                    end
                end
            end
            ST_DIVA:
            begin
                if (div_done)
                begin
                    speed_avg_next = div_quot[PSW_SPEED_W-1:0];
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.accepted      = acc_flag_reg;
                    out_data_next.current_speed = speed_now_reg;
                    out_data_next.average_speed = speed_avg_reg;
                    out_data_next.window_closed = closed_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_ms_reg <= PSW_WIN_RESET;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_time_reg <= '0;
            win_start_reg <= '0;
            speed_now_reg <= '0;
            speed_avg_reg <= '0;
            speed_sum_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            last_time_reg <= last_time_next;
            win_start_reg <= win_start_next;
            speed_now_reg <= speed_now_next;
            speed_avg_reg <= speed_avg_next;
            speed_sum_reg <= speed_sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                window_ms_reg <= cfg_wdata;
            end
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        time_reg     <= time_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        dt_reg       <= dt_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        acc_reg      <= acc_next;
        spd_reg      <= spd_next;
        acc_flag_reg <= acc_flag_next;
        closed_reg   <= closed_next;
        out_data_reg <= out_data_next;
    end

    // Square root of the scaled squared distance
    psw_isqrt #(
        .ROOT_W(ROOT_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand ((2 * ROOT_W)'(acc_next)),
        .done     (root_done),
        .root     (root_val)
    );

    // Shared divider for speed and window average
    psw_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/psw_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on psw_pkg only for the default root width (no shared types used here).
`timescale 1ns / 1ps

module psw_isqrt
    import psw_pkg::*;
#(
    parameter int ROOT_W = PSW_POS_WIDTH + 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic                  done,
    output logic [ROOT_W-1:0]     root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;

    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;

    // One digit step: bring down two radicand bits, try (root << 2) | 1
    always_comb
    begin
        rem_sh    = {rem_reg[ROOT_W-1:0], rad_reg[2*ROOT_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rad_next = {rad_reg[2*ROOT_W-3:0], 2'b00};
                cnt_next = cnt_reg - 1'b1;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign root = root_reg;

endmodule

// ===== sv/psw_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Shared between the speed division and the window average; uses psw_pkg types.
`timescale 1ns / 1ps

module psw_divider
    import psw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  psw_div_req_t             req,
    output logic                     done,
    output logic [PSW_DIV_NUM_W-1:0] quotient
);

    logic [PSW_DIV_DEN_W:0]   rem_reg, rem_next;
    logic [PSW_DIV_NUM_W-1:0] num_reg, num_next;
    logic [PSW_DIV_DEN_W-1:0] den_reg, den_next;
    logic [PSW_DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;

    logic [PSW_DIV_DEN_W:0]   rem_sh;

    // Shift one dividend bit into the remainder, subtract if it fits.
    // The dividend arrives left-aligned; quotient bits fill from the bottom.
    always_comb
    begin
        rem_sh    = {rem_reg[PSW_DIV_DEN_W-1:0], num_reg[PSW_DIV_NUM_W-1]};
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            rem_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
            cnt_next  = req.bits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    num_next = {num_reg[PSW_DIV_NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    num_next = {num_reg[PSW_DIV_NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = num_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for pointer_speed_window_meter_top: random and directed requests,
// a scoreboard class that predicts each result, random idling on both sides.
// Depends on psw_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import psw_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD    = 600;

    // Predicts the result of every request and checks results in order
    class speed_scoreboard;
        logic [PSW_WIN_W-1:0]          window_len;
        logic signed [PSW_FIELD_W-1:0] prev_x;
        logic signed [PSW_FIELD_W-1:0] prev_y;
        logic [PSW_TIME_W-1:0]         prev_time;
        logic [PSW_TIME_W-1:0]         window_start;
        logic [PSW_SPEED_W-1:0]        speed_now;
        logic [PSW_SPEED_W-1:0]        speed_avg;
        logic [PSW_SUM_W-1:0]          speed_sum;
        logic [PSW_COUNT_W-1:0]        sample_count;
        psw_out_t                      expected_results[$];
        int                            errors;

        function new();
            window_len   = PSW_WIN_RESET;
            prev_x       = '0;
            prev_y       = '0;
            prev_time    = '0;
            window_start = '0;
            speed_now    = '0;
            speed_avg    = '0;
            speed_sum    = '0;
            sample_count = '0;
            errors       = 0;
        endfunction

        function void set_window(logic [PSW_WIN_W-1:0] len);
            window_len = len;
        endfunction

        // Floor square root, one result bit at a time from the top
        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int i = 31; i >= 0; i--)
            begin
                trial = r | (64'd1 << i);
                if (trial * trial <= v)
                    r = trial;
            end
            return r;
        endfunction

        // Works out the result of an accepted request and queues it
        function void note_request(psw_in_t req);
            logic [PSW_TIME_W-1:0] dt;
            logic [PSW_TIME_W-1:0] since_start;
            longint                dx;
            longint                dy;
            longint unsigned       travel;
            longint unsigned       spd;
            psw_out_t              want;
            logic                  closed;
            dt     = req.time_ms - prev_time;
            closed = 1'b0;
            if (dt != '0)
            begin
                dx     = longint'(req.pos_x) - longint'(prev_x);
                dy     = longint'(req.pos_y) - longint'(prev_y);
                travel = root_floor(64'(dx * dx + dy * dy) * 64'(PSW_MS_PER_S)
                                    * 64'(PSW_MS_PER_S));
                spd    = travel / 64'(dt);
                if (spd > 64'(PSW_SPEED_MAX))
                    spd = 64'(PSW_SPEED_MAX);
                speed_now = PSW_SPEED_W'(spd);
                prev_x    = req.pos_x;
                prev_y    = req.pos_y;
                prev_time = req.time_ms;
                // a full count keeps further samples out of the sum until the window closes
                if (sample_count < PSW_COUNT_MAX)
                begin
                    speed_sum    = speed_sum + PSW_SUM_W'(spd);
                    sample_count = sample_count + 1'b1;
                end
                since_start = req.time_ms - window_start;
                if (since_start >= PSW_TIME_W'(window_len))
                begin
                    if (sample_count != '0)
                        speed_avg = PSW_SPEED_W'(speed_sum / PSW_SUM_W'(sample_count));
                    window_start = req.time_ms;
                    speed_sum    = '0;
                    sample_count = '0;
                    closed       = 1'b1;
                end
            end
            want.accepted      = (dt != '0);
            want.current_speed = speed_now;
            want.average_speed = speed_avg;
            want.window_closed = closed;
            expected_results   = {expected_results, want};
        endfunction

        // Compares a result with the oldest expectation
        function void check_result(psw_out_t got);
            psw_out_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: %p", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.accepted !== want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                errors++;
            end
            if (got.current_speed !== want.current_speed)
            begin
                $error("current_speed: expected %0d, got %0d",
                       want.current_speed, got.current_speed);
                errors++;
            end
            if (got.average_speed !== want.average_speed)
            begin
                $error("average_speed: expected %0d, got %0d",
                       want.average_speed, got.average_speed);
                errors++;
            end
            if (got.window_closed !== want.window_closed)
            begin
                $error("window_closed: expected %0d, got %0d",
                       want.window_closed, got.window_closed);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [PSW_WIN_W-1:0] cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    psw_in_t              in_data;
    logic                 out_valid;
    logic                 out_ready;
    psw_out_t             out_data;

    speed_scoreboard meter = new();

    int tx_idle_pct;
    int rx_idle_pct;
    bit long_hold_pending;
    int cycle_count;

    // Pointer walk that the random requests follow
    logic [PSW_TIME_W-1:0]          walk_time;
    logic signed [PSW_FIELD_W-1:0]  walk_x;
    logic signed [PSW_FIELD_W-1:0]  walk_y;

    pointer_speed_window_meter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic psw_in_t make_req(logic [PSW_TIME_W-1:0] t,
                                         logic [PSW_FIELD_W-1:0] x,
                                         logic [PSW_FIELD_W-1:0] y);
        psw_in_t req;
        req.time_ms = t;
        req.pos_x   = x;
        req.pos_y   = y;
        return req;
    endfunction

    // Mostly small steps in time and position; some repeated timestamps,
    // long or backward jumps in time, and fully random requests
    function automatic psw_in_t next_request();
        int pick;
        int span;
        pick = int'($urandom_range(99));
        span = ($urandom_range(9) < 7) ? 300 : (($urandom_range(3) == 0) ? 32767 : 4000);
        if (pick < 72)
            walk_time = walk_time + PSW_TIME_W'($urandom_range(1, 40));
        else if (pick >= 82 && pick < 90)
            walk_time = walk_time + PSW_TIME_W'($urandom);
        if (pick < 90)
        begin
            walk_x = walk_x + PSW_FIELD_W'($urandom_range(0, 2 * span) - span);
            walk_y = walk_y + PSW_FIELD_W'($urandom_range(0, 2 * span) - span);
        end
        else
        begin
            walk_time = PSW_TIME_W'($urandom);
            walk_x    = PSW_FIELD_W'($urandom);
            walk_y    = PSW_FIELD_W'($urandom);
        end
        return make_req(walk_time, walk_x, walk_y);
    endfunction

    // Offers one request, entered and left at a falling edge
    task automatic drive_request(input psw_in_t req);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        meter.note_request(req);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (meter.expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input logic [PSW_WIN_W-1:0] len, input int count,
                             input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        meter.set_window(len);
        @(negedge clk);
        cfg_we <= 1'b0;
        repeat (count)
            drive_request(next_request());
        wait_idle();
    endtask

    // Receiver: takes results, idles at random, and holds off once for a long stretch
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                meter.check_result(out_data);
            @(negedge clk);
            if (long_hold_pending && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    // Stimulus
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_valid          = 1'b0;
        in_data           = '0;
        out_ready         = 1'b0;
        tx_idle_pct       = 24;
        rx_idle_pct       = 67;
        long_hold_pending = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset window of 1000 ms
        drive_request(make_req(32'd0, 16'h0000, 16'h0000));       // no time elapsed
        drive_request(make_req(32'd10, 16'h7FFF, 16'h8000));
        drive_request(make_req(32'd11, 16'h8000, 16'h7FFF));      // largest move in 1 ms
        drive_request(make_req(32'd11, 16'h0064, 16'h0064));      // repeat, held values
        drive_request(make_req(32'd12, 16'h8000, 16'h7FFF));      // no movement
        drive_request(make_req(32'd999, 16'h0005, 16'h0005));
        drive_request(make_req(32'd1000, 16'h0000, 16'h0000));    // window exactly reached
        drive_request(make_req(32'd1999, 16'h5555, 16'hAAAA));
        drive_request(make_req(32'd2000, 16'hAAAA, 16'h5555));
        drive_request(make_req(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        drive_request(make_req(32'd0, 16'h0000, 16'h0000));       // time wraps
        drive_request(make_req(32'h5555_5555, 16'h5555, 16'h5555));
        drive_request(make_req(32'hAAAA_AAAA, 16'hAAAA, 16'hAAAA));
        drive_request(make_req(32'h8000_0000, 16'h7FFF, 16'h7FFF));
        drive_request(make_req(32'h7FFF_FFFF, 16'h8000, 16'h8000)); // backward in time
        drive_request(make_req(32'h8000_01F3, 16'h0001, 16'hFFFE));
        wait_idle();
        walk_time = 32'h8000_01F3;
        walk_x    = 16'sh0001;
        walk_y    = -16'sh0002;

        // Random part across several window lengths
        run_phase(16'd50, 240, 24, 67);
        run_phase(16'd1, 200, 24, 67);
        run_phase(16'hFFFF, 200, 67, 24);
        run_phase(16'd0, 200, 67, 24);
        long_hold_pending = 1'b1;
        run_phase(PSW_WIN_W'($urandom_range(20, 500)), 250, 0, 0);
        run_phase(16'd1000, 240, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (meter.expected_results.size() != 0)
        begin
            $error("%0d results never arrived", meter.expected_results.size());
            meter.errors++;
        end
        if (meter.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
